FILE: design/fcr_pkg.sv
package fcr_pkg;

  localparam int MAX_PAYLOAD = 16;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] CRC_INIT = 8'h00;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_ID,
    PH_CMD,
    PH_LEN,
    PH_PAY,
    PH_CRC,
    PH_END
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_SPEED    = 3'd1,
    EV_GAINS    = 3'd2,
    EV_STATUS   = 3'd3,
    EV_SETTINGS = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    RPL_NONE = 2'd0,
    RPL_ACK  = 2'd1,
    RPL_NACK = 2'd2
  } reply_e;

  typedef enum logic [1:0] {
    RSN_BAD_CRC = 2'd0,
    RSN_BAD_LEN = 2'd1,
    RSN_BAD_CMD = 2'd2
  } reason_e;

  typedef enum logic [7:0] {
    CFG_START_BYTE    = 8'd0,
    CFG_END_BYTE      = 8'd1,
    CFG_OWN_ADDRESS   = 8'd2,
    CFG_GAP_TIMEOUT   = 8'd3,
    CFG_CODE_SPEED    = 8'd4,
    CFG_CODE_GAINS    = 8'd5,
    CFG_CODE_STATUS   = 8'd6,
    CFG_CODE_SETTINGS = 8'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        time_present;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_code;
    logic [1:0]  reply_kind;
    logic [1:0]  nack_reason;
    logic [31:0] speed_bits;
    logic [31:0] gain_p_bits;
    logic [31:0] gain_i_bits;
    logic [31:0] gain_d_bits;
    logic [31:0] gap_timeouts;
  } out_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [7:0]  own_address;
    logic [31:0] gap_timeout_ms;
    logic [7:0]  code_set_speed;
    logic [7:0]  code_set_gains;
    logic [7:0]  code_req_status;
    logic [7:0]  code_req_settings;
  } cfg_t;

  // One classified byte on its way to the back end
  typedef struct packed {
    logic [2:0]  event_code;
    logic [1:0]  reply_kind;
    logic [1:0]  nack_reason;
    logic        upd_speed;
    logic        upd_gains;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] gap_timeouts;
  } disp_t;

  // Reflected CRC-8, one byte, LSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[0] ^ data[k];
      crc = {1'b0, crc[7:1]};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

FILE: design/framed_command_receiver_crc8.sv
// Channel   Signals                                 Word
// input     in_valid_i / in_ready_o / in_data_i     one received byte (in_t)
// output    out_valid_o / out_ready_i / out_data_o  one result per byte (out_t)
// config    cfg_valid_i / cfg_ready_o / cfg_addr_i  register index and cfg_data_i
//
// One byte a cycle while the queue has room: the front end parses, checks
// the gap and updates the CRC in the cycle it takes the byte; the back end
// stores the words and registers the result when it pops the record.
// A two-entry queue between the two halves lets either side stall on its own.
// Reset is asynchronous and active low; the config port is always ready.
module framed_command_receiver_crc8
  import fcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t  cfg;
  logic  push_valid, push_ready;
  disp_t push_data;
  logic  pop_valid, pop_ready;
  disp_t pop_data;

  fcr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  fcr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  fcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/fcr_cfg.sv
module fcr_cfg
  import fcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_START_BYTE:    cfg_d.start_byte        = cfg_data_i[7:0];
        CFG_END_BYTE:      cfg_d.end_byte          = cfg_data_i[7:0];
        CFG_OWN_ADDRESS:   cfg_d.own_address       = cfg_data_i[7:0];
        CFG_GAP_TIMEOUT:   cfg_d.gap_timeout_ms    = cfg_data_i;
        CFG_CODE_SPEED:    cfg_d.code_set_speed    = cfg_data_i[7:0];
        CFG_CODE_GAINS:    cfg_d.code_set_gains    = cfg_data_i[7:0];
        CFG_CODE_STATUS:   cfg_d.code_req_status   = cfg_data_i[7:0];
        CFG_CODE_SETTINGS: cfg_d.code_req_settings = cfg_data_i[7:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte        <= 8'd2;
      cfg_q.end_byte          <= 8'd3;
      cfg_q.own_address       <= 8'd1;
      cfg_q.gap_timeout_ms    <= 32'd50;
      cfg_q.code_set_speed    <= 8'd1;
      cfg_q.code_set_gains    <= 8'd2;
      cfg_q.code_req_status   <= 8'd3;
      cfg_q.code_req_settings <= 8'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: design/fcr_front.sv
module fcr_front
  import fcr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_data_i,
  output logic  push_valid_o,
  input  logic  push_ready_i,
  output disp_t push_data_o
);

  phase_e      phase_q, phase_d, phase_cur;
  logic [31:0] last_q;
  logic [31:0] tout_q;
  logic [7:0]  cmd_q;
  logic [7:0]  len_q;
  logic [CNT_W-1:0] cnt_q, cnt_inc;
  logic [7:0]  crc_q, crc_next;
  logic [7:0]  fcrc_q;
  logic [7:0]  store_q [MAX_PAYLOAD];

  logic        in_fire;
  logic        timed_out;
  logic        room;
  logic [7:0]  b;
  logic [31:0] gap;

  assign in_fire      = in_valid_i && push_ready_i;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign b            = in_data_i.rx_byte;
  assign gap          = in_data_i.now_ms - last_q;
  assign timed_out    = in_data_i.time_present && (phase_q != PH_WAIT)
                        && (gap > cfg_i.gap_timeout_ms);
  assign phase_cur    = timed_out ? PH_WAIT : phase_q;
  assign room         = cnt_q < CNT_W'(MAX_PAYLOAD);
  assign cnt_inc      = cnt_q + CNT_W'(room);
  assign crc_next     = crc8_step((phase_cur == PH_ID) ? CRC_INIT : crc_q, b);

  // Next state
  always_comb begin
    case (phase_cur)
      PH_WAIT: phase_d = (b == cfg_i.start_byte) ? PH_ID : PH_WAIT;
      PH_ID:   phase_d = (b == cfg_i.own_address) ? PH_CMD : PH_WAIT;
      PH_CMD:  phase_d = PH_LEN;
      PH_LEN: begin
        if (b > MAX_LEN) begin
          phase_d = PH_WAIT;
        end else begin
          phase_d = (b != 8'd0) ? PH_PAY : PH_CRC;
        end
      end
      PH_PAY:  phase_d = (8'(cnt_inc) >= len_q) ? PH_CRC : PH_PAY;
      PH_CRC:  phase_d = PH_END;
      PH_END:  phase_d = PH_WAIT;
      default: phase_d = PH_WAIT;
    endcase
  end

  // Classify the word and build the dispatch record
  always_comb begin
    push_data_o.event_code   = EV_NONE;
    push_data_o.reply_kind   = RPL_NONE;
    push_data_o.nack_reason  = RSN_BAD_CRC;
    push_data_o.upd_speed    = 1'b0;
    push_data_o.upd_gains    = 1'b0;
    push_data_o.word0        = {store_q[3], store_q[2], store_q[1], store_q[0]};
    push_data_o.word1        = {store_q[7], store_q[6], store_q[5], store_q[4]};
    push_data_o.word2        = {store_q[11], store_q[10], store_q[9], store_q[8]};
    push_data_o.gap_timeouts = tout_q + 32'(timed_out);
    if (phase_cur == PH_END && b == cfg_i.end_byte) begin
      if (crc_q != fcrc_q) begin
        push_data_o.reply_kind  = RPL_NACK;
        push_data_o.nack_reason = RSN_BAD_CRC;
      end else if (cmd_q == cfg_i.code_set_speed) begin
        if (len_q == 8'd4) begin
          push_data_o.upd_speed  = 1'b1;
          push_data_o.reply_kind = RPL_ACK;
          push_data_o.event_code = EV_SPEED;
        end else begin
          push_data_o.reply_kind  = RPL_NACK;
          push_data_o.nack_reason = RSN_BAD_LEN;
        end
      end else if (cmd_q == cfg_i.code_set_gains) begin
        if (len_q == 8'd12) begin
          push_data_o.upd_gains  = 1'b1;
          push_data_o.reply_kind = RPL_ACK;
          push_data_o.event_code = EV_GAINS;
        end else begin
          push_data_o.reply_kind  = RPL_NACK;
          push_data_o.nack_reason = RSN_BAD_LEN;
        end
      end else if (cmd_q == cfg_i.code_req_status) begin
        if (len_q == 8'd0) begin
          push_data_o.event_code = EV_STATUS;
        end else begin
          push_data_o.reply_kind  = RPL_NACK;
          push_data_o.nack_reason = RSN_BAD_LEN;
        end
      end else if (cmd_q == cfg_i.code_req_settings) begin
        if (len_q == 8'd0) begin
          push_data_o.event_code = EV_SETTINGS;
        end else begin
          push_data_o.reply_kind  = RPL_NACK;
          push_data_o.nack_reason = RSN_BAD_LEN;
        end
      end else begin
        push_data_o.reply_kind  = RPL_NACK;
        push_data_o.nack_reason = RSN_BAD_CMD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      last_q  <= '0;
      tout_q  <= '0;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      crc_q   <= CRC_INIT;
      fcrc_q  <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      if (in_data_i.time_present) begin
        last_q <= in_data_i.now_ms;
      end
      if (timed_out) begin
        tout_q <= tout_q + 32'd1;
      end
      case (phase_cur)
        PH_ID:  crc_q <= crc_next;
        PH_CMD: begin
          cmd_q <= b;
          crc_q <= crc_next;
        end
        PH_LEN: begin
          len_q <= b;
          cnt_q <= '0;
          crc_q <= crc_next;
        end
        PH_PAY: begin
          cnt_q <= cnt_inc;
          crc_q <= crc_next;
        end
        PH_CRC: fcrc_q <= b;
        default: ;
      endcase
    end
  end

  // Payload bytes; only entries written in the current frame are ever used
  always_ff @(posedge clk_i) begin
    if (in_fire && phase_cur == PH_PAY && room) begin
      store_q[cnt_q[IDX_W-1:0]] <= b;
    end
  end

endmodule

FILE: design/fcr_fifo.sv
module fcr_fifo
  import fcr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  disp_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output disp_t pop_data_o
);

  disp_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/fcr_back.sv
module fcr_back
  import fcr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  pop_valid_i,
  output logic  pop_ready_o,
  input  disp_t pop_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_data_o
);

  logic        out_valid_q;
  out_t        out_q;
  logic [31:0] speed_q, speed_d;
  logic [31:0] gp_q, gp_d, gi_q, gi_d, gd_q, gd_d;
  logic        pop;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Apply the stored-word updates carried by the record
  always_comb begin
    speed_d = pop_data_i.upd_speed ? pop_data_i.word0 : speed_q;
    gp_d    = pop_data_i.upd_gains ? pop_data_i.word0 : gp_q;
    gi_d    = pop_data_i.upd_gains ? pop_data_i.word1 : gi_q;
    gd_d    = pop_data_i.upd_gains ? pop_data_i.word2 : gd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      speed_q     <= '0;
      gp_q        <= '0;
      gi_q        <= '0;
      gd_q        <= '0;
    end else begin
      if (pop) begin
        out_valid_q <= 1'b1;
        speed_q     <= speed_d;
        gp_q        <= gp_d;
        gi_q        <= gi_d;
        gd_q        <= gd_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q.event_code   <= pop_data_i.event_code;
      out_q.reply_kind   <= pop_data_i.reply_kind;
      out_q.nack_reason  <= pop_data_i.nack_reason;
      out_q.speed_bits   <= speed_d;
      out_q.gain_p_bits  <= gp_d;
      out_q.gain_i_bits  <= gi_d;
      out_q.gain_d_bits  <= gd_d;
      out_q.gap_timeouts <= pop_data_i.gap_timeouts;
    end
  end

endmodule

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam logic [7:0]  CFG_NO_REG  = 8'd8;  // one past the last register
  localparam logic [7:0]  SPEED_LEN   = 8'd4;
  localparam logic [7:0]  GAINS_LEN   = 8'd12;
  localparam int          PHASE_BYTES = 64;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_addr  = '0;
  logic [31:0] cfg_data  = '0;

  always #5 clk_i = ~clk_i;

  framed_command_receiver_crc8 i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data)
  );

  // Receiver model: registers and parser state
  cfg_t        regs;
  phase_e      parse_ph;
  logic [31:0] last_stamp;
  logic [31:0] timeout_count;
  logic [31:0] speed_w;
  logic [31:0] gain_w [3];
  logic [7:0]  cmd_r, len_r, crc_run, crc_rx;
  logic [4:0]  pay_cnt;
  logic [7:0]  pay_mem [MAX_PAYLOAD];

  // Stimulus and scoreboard state
  in_t         byte_q [$];
  out_t        awaited [$];
  logic [31:0] ms_now;
  bit          jump_next = 1'b0;
  logic        in_fire = 1'b0;
  int          bytes_queued = 0;
  int          checked = 0;
  int          fail_count = 0;
  int          acks = 0, nacks = 0, requests = 0;
  int          burst_left = 0, gap_left = 0;
  int unsigned cycles = 0;
  int unsigned stall_ctr = 0;
  int          ready_mode = 0;

  function automatic logic [7:0] crc_update(logic [7:0] c, logic [7:0] d);
    logic [7:0] x;
    x = c ^ d;
    repeat (8) x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    return x;
  endfunction

  function automatic logic [31:0] payload_word(int base);
    return {pay_mem[base + 3], pay_mem[base + 2], pay_mem[base + 1], pay_mem[base]};
  endfunction

  function automatic out_t parse_byte(in_t w);
    out_t       r;
    logic [7:0] b;
    r = '0;
    b = w.rx_byte;
    if (w.time_present) begin
      // drop the frame if the gap since the last stamped byte is too long
      if (parse_ph != PH_WAIT && (w.now_ms - last_stamp) > regs.gap_timeout_ms) begin
        parse_ph      = PH_WAIT;
        timeout_count = timeout_count + 1;
      end
      last_stamp = w.now_ms;
    end
    case (parse_ph)
      PH_ID: begin
        crc_run  = crc_update(CRC_INIT, b);
        parse_ph = (b == regs.own_address) ? PH_CMD : PH_WAIT;
      end
      PH_CMD: begin
        cmd_r    = b;
        crc_run  = crc_update(crc_run, b);
        parse_ph = PH_LEN;
      end
      PH_LEN: begin
        len_r   = b;
        pay_cnt = '0;
        crc_run = crc_update(crc_run, b);
        if (b > MAX_LEN) begin
          parse_ph = PH_WAIT;
        end else begin
          parse_ph = (b != 8'd0) ? PH_PAY : PH_CRC;
        end
      end
      PH_PAY: begin
        pay_mem[pay_cnt[3:0]] = b;
        pay_cnt = pay_cnt + 1;
        crc_run = crc_update(crc_run, b);
        if (pay_cnt >= len_r) parse_ph = PH_CRC;
      end
      PH_CRC: begin
        crc_rx   = b;
        parse_ph = PH_END;
      end
      PH_END: begin
        if (b == regs.end_byte) begin
          if (crc_run != crc_rx) begin
            r.reply_kind  = RPL_NACK;
            r.nack_reason = RSN_BAD_CRC;
          end else if (cmd_r == regs.code_set_speed) begin
            if (len_r == SPEED_LEN) begin
              speed_w      = payload_word(0);
              r.reply_kind = RPL_ACK;
              r.event_code = EV_SPEED;
            end else begin
              r.reply_kind  = RPL_NACK;
              r.nack_reason = RSN_BAD_LEN;
            end
          end else if (cmd_r == regs.code_set_gains) begin
            if (len_r == GAINS_LEN) begin
              gain_w[0]    = payload_word(0);
              gain_w[1]    = payload_word(4);
              gain_w[2]    = payload_word(8);
              r.reply_kind = RPL_ACK;
              r.event_code = EV_GAINS;
            end else begin
              r.reply_kind  = RPL_NACK;
              r.nack_reason = RSN_BAD_LEN;
            end
          end else if (cmd_r == regs.code_req_status) begin
            if (len_r == 8'd0) begin
              r.event_code = EV_STATUS;
            end else begin
              r.reply_kind  = RPL_NACK;
              r.nack_reason = RSN_BAD_LEN;
            end
          end else if (cmd_r == regs.code_req_settings) begin
            if (len_r == 8'd0) begin
              r.event_code = EV_SETTINGS;
            end else begin
              r.reply_kind  = RPL_NACK;
              r.nack_reason = RSN_BAD_LEN;
            end
          end else begin
            r.reply_kind  = RPL_NACK;
            r.nack_reason = RSN_BAD_CMD;
          end
        end
        parse_ph = PH_WAIT;
      end
      default: begin
        parse_ph = (b == regs.start_byte) ? PH_ID : PH_WAIT;
      end
    endcase
    r.speed_bits   = speed_w;
    r.gain_p_bits  = gain_w[0];
    r.gain_i_bits  = gain_w[1];
    r.gain_d_bits  = gain_w[2];
    r.gap_timeouts = timeout_count;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Stamp one byte with a time and queue it for the driver
  function automatic void send_byte(logic [7:0] b);
    in_t         w;
    logic [31:0] step;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w.time_present = ($urandom_range(0, 7) != 0);
    if (jump_next) begin
      step           = regs.gap_timeout_ms + 1;
      w.time_present = 1'b1;
      jump_next      = 1'b0;
    end else if (pick == 0) begin
      step = regs.gap_timeout_ms;
    end else if (pick == 1) begin
      step = regs.gap_timeout_ms + 1 + $urandom_range(0, 20);
    end else begin
      step = (regs.gap_timeout_ms >= 3) ? $urandom_range(0, 3) : 0;
    end
    ms_now   += step;
    w.rx_byte = b;
    w.now_ms  = w.time_present ? ms_now : $urandom;
    byte_q.push_back(w);
    bytes_queued++;
  endfunction

  // fill < 0 gives random payload; cut > 0 truncates the frame to that many bytes
  function automatic void queue_frame(logic [7:0] id, logic [7:0] cmd, logic [7:0] len,
                                      int fill, int cut, bit bad_crc, bit bad_end);
    logic [7:0] frm [$];
    logic [7:0] c, b;
    int         n;
    frm.push_back(regs.start_byte);
    frm.push_back(id);
    frm.push_back(cmd);
    frm.push_back(len);
    c = crc_update(crc_update(crc_update(CRC_INIT, id), cmd), len);
    n = (len > MAX_LEN) ? $urandom_range(0, 3) : int'(len);
    for (int k = 0; k < n; k++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      c = crc_update(c, b);
      frm.push_back(b);
    end
    frm.push_back(bad_crc ? c ^ 8'($urandom_range(1, 255)) : c);
    frm.push_back(bad_end ? regs.end_byte ^ 8'($urandom_range(1, 255)) : regs.end_byte);
    if (cut > 0) begin
      while (frm.size() > cut) void'(frm.pop_back());
    end
    foreach (frm[k]) send_byte(frm[k]);
  endfunction

  function automatic void random_traffic(int target);
    logic [7:0]  cmd, len, id;
    int          first, cut;
    int unsigned pick;
    first = bytes_queued;
    while (bytes_queued - first < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin cmd = regs.code_set_speed;    len = SPEED_LEN; end
        3, 4, 5: begin cmd = regs.code_set_gains;    len = GAINS_LEN; end
        6:       begin cmd = regs.code_req_status;   len = 8'd0;      end
        7:       begin cmd = regs.code_req_settings; len = 8'd0;      end
        default: begin cmd = 8'($urandom); len = 8'($urandom_range(0, MAX_PAYLOAD)); end
      endcase
      pick = $urandom_range(0, 29);
      if (pick == 0) begin
        len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
      end else if (pick < 4) begin
        len = 8'($urandom_range(0, MAX_PAYLOAD));
      end
      id  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : regs.own_address;
      cut = ($urandom_range(0, 14) == 0) ? $urandom_range(1, 6) : 0;
      queue_frame(id, cmd, len, -1, cut, $urandom_range(0, 9) == 0, $urandom_range(0, 11) == 0);
    end
    // leave a frame open so the next register write lands mid-frame
    queue_frame(regs.own_address, regs.code_set_speed, SPEED_LEN, -1, 3, 1'b0, 1'b0);
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.start_byte        = 8'($urandom);
    s.end_byte          = 8'($urandom);
    s.own_address       = 8'($urandom);
    s.gap_timeout_ms    = $urandom_range(1, 200);
    s.code_set_speed    = 8'($urandom);
    s.code_set_gains    = 8'($urandom);
    s.code_req_status   = 8'($urandom);
    s.code_req_settings = 8'($urandom);
    return s;
  endfunction

  task automatic write_reg(logic [7:0] addr, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (addr)
      CFG_START_BYTE:    regs.start_byte        = data[7:0];
      CFG_END_BYTE:      regs.end_byte          = data[7:0];
      CFG_OWN_ADDRESS:   regs.own_address       = data[7:0];
      CFG_GAP_TIMEOUT:   regs.gap_timeout_ms    = data;
      CFG_CODE_SPEED:    regs.code_set_speed    = data[7:0];
      CFG_CODE_GAINS:    regs.code_set_gains    = data[7:0];
      CFG_CODE_STATUS:   regs.code_req_status   = data[7:0];
      CFG_CODE_SETTINGS: regs.code_req_settings = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(cfg_t s);
    write_reg(CFG_START_BYTE,    32'(s.start_byte));
    write_reg(CFG_END_BYTE,      32'(s.end_byte));
    write_reg(CFG_OWN_ADDRESS,   32'(s.own_address));
    write_reg(CFG_GAP_TIMEOUT,   s.gap_timeout_ms);
    write_reg(CFG_CODE_SPEED,    32'(s.code_set_speed));
    write_reg(CFG_CODE_GAINS,    32'(s.code_set_gains));
    write_reg(CFG_CODE_STATUS,   32'(s.code_req_status));
    write_reg(CFG_CODE_SETTINGS, 32'(s.code_req_settings));
  endtask

  // Wait until every queued byte has gone in and every result has come out
  task automatic drain();
    do @(posedge clk_i);
    while (byte_q.size() != 0 || in_valid || awaited.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Sender: bursts of random length with random gaps between them
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= byte_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
          gap_left   = $urandom_range(0, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall pattern, chosen from four modes
  always @(negedge clk_i) begin
    stall_ctr++;
    if (stall_ctr % 128 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 9) < 7);
      2:       out_ready <= (stall_ctr % 8 != 3) && (stall_ctr % 8 != 7);
      default: out_ready <= (stall_ctr % 32 >= 8);
    endcase
  end

  always @(posedge clk_i) begin : track
    out_t want;
    in_fire <= rst_ni && in_valid && in_ready;
    if (rst_ni && in_valid && in_ready) begin
      want = parse_byte(in_data);
      awaited.push_back(want);
      if (want.reply_kind == RPL_ACK) acks++;
      if (want.reply_kind == RPL_NACK) nacks++;
      if (want.event_code == EV_STATUS || want.event_code == EV_SETTINGS) requests++;
    end
    if (rst_ni && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        $error("result word with no result awaited");
        fail_count++;
      end else begin
        want = awaited.pop_front();
        check_field("event_code",   32'(want.event_code),  32'(out_data.event_code));
        check_field("reply_kind",   32'(want.reply_kind),  32'(out_data.reply_kind));
        check_field("nack_reason",  32'(want.nack_reason), 32'(out_data.nack_reason));
        check_field("speed_bits",   want.speed_bits,       out_data.speed_bits);
        check_field("gain_p_bits",  want.gain_p_bits,      out_data.gain_p_bits);
        check_field("gain_i_bits",  want.gain_i_bits,      out_data.gain_i_bits);
        check_field("gain_d_bits",  want.gain_d_bits,      out_data.gain_d_bits);
        check_field("gap_timeouts", want.gap_timeouts,     out_data.gap_timeouts);
        checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    cfg_t s;
    regs = '{start_byte: 8'd2, end_byte: 8'd3, own_address: 8'd1, gap_timeout_ms: 32'd50,
             code_set_speed: 8'd1, code_set_gains: 8'd2, code_req_status: 8'd3,
             code_req_settings: 8'd4};
    parse_ph      = PH_WAIT;
    last_stamp    = '0;
    timeout_count = '0;
    speed_w       = '0;
    gain_w        = '{default: '0};
    cmd_r         = '0;
    len_r         = '0;
    crc_run       = '0;
    crc_rx        = '0;
    pay_cnt       = '0;
    pay_mem       = '{default: '0};
    // start close to the top so the timestamps wrap early
    ms_now        = 32'hFFFF_FFE0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset settings
    queue_frame(regs.own_address, regs.code_set_speed, SPEED_LEN, 8'hFF, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, regs.code_set_gains, GAINS_LEN, -1, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, regs.code_set_speed, SPEED_LEN, 8'h00, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, regs.code_req_status, 8'd0, -1, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, regs.code_req_settings, 8'd0, -1, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, regs.code_set_speed, SPEED_LEN, -1, 0, 1'b1, 1'b0);
    queue_frame(regs.own_address, regs.code_set_speed, 8'd3, -1, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, regs.code_set_gains, MAX_LEN, -1, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, regs.code_req_status, 8'd1, -1, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, regs.code_req_settings, 8'd2, -1, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, 8'hFF, MAX_LEN, -1, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, 8'h00, 8'd0, -1, 0, 1'b0, 1'b0);
    queue_frame(8'h00, regs.code_set_speed, SPEED_LEN, -1, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, regs.code_set_speed, MAX_LEN + 8'd1, -1, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, regs.code_set_speed, 8'hFF, -1, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, regs.code_set_gains, GAINS_LEN, -1, 0, 1'b0, 1'b1);
    // stall mid-frame past the timeout; the late start byte opens a fresh frame
    queue_frame(regs.own_address, regs.code_set_gains, GAINS_LEN, -1, 5, 1'b0, 1'b0);
    jump_next = 1'b1;
    queue_frame(regs.own_address, regs.code_set_speed, SPEED_LEN, -1, 0, 1'b0, 1'b0);
    queue_frame(regs.own_address, regs.code_set_speed, SPEED_LEN, -1, 3, 1'b0, 1'b0);
    drain();

    // An unmapped index must leave every register alone
    write_reg(CFG_NO_REG, 32'hFFFF_FFFF);
    s = random_settings();
    apply_settings(s);
    random_traffic(PHASE_BYTES);
    drain();

    // Low extremes, zero timeout
    s = '{start_byte: 8'h00, end_byte: 8'hFF, own_address: 8'h00, gap_timeout_ms: 32'd0,
          code_set_speed: 8'h00, code_set_gains: 8'hFF, code_req_status: 8'h80,
          code_req_settings: 8'h7F};
    apply_settings(s);
    random_traffic(PHASE_BYTES);
    drain();

    // High extremes; equal codes so the speed command takes precedence
    s = '{start_byte: 8'hFF, end_byte: 8'h00, own_address: 8'hFF,
          gap_timeout_ms: 32'hFFFF_FFFF, code_set_speed: 8'h5A, code_set_gains: 8'h5A,
          code_req_status: 8'h5A, code_req_settings: 8'h5A};
    apply_settings(s);
    random_traffic(PHASE_BYTES);
    drain();

    s = random_settings();
    apply_settings(s);
    random_traffic(PHASE_BYTES);
    drain();

    if (awaited.size() != 0) begin
      $error("%0d results never arrived", awaited.size());
      fail_count++;
    end
    $display("Checked %0d results for %0d bytes under five register settings,",
             checked, bytes_queued);
    $display("with %0d ACKs, %0d NACKs, %0d requests and %0d gap timeouts.",
             acks, nacks, requests, timeout_count);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
